[rtl/core/qau_pkg.sv]
// Shared constants, codes and types of the quaternion arithmetic unit.
// Used by the norm unit, the component lanes and the top level; no dependencies.
package qau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;

  localparam int PROD_W   = 2 * WORD_BITS;
  localparam int HSUM_W   = PROD_W + 2;
  localparam int RND_W    = HSUM_W - FRAC_BITS;
  localparam int SQ_SUM_W = PROD_W + 1;
  localparam int ROOT_W   = WORD_BITS + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int QUO_W    = WORD_BITS + 1;
  localparam int DIV_W    = ((WORD_BITS + 2 * FRAC_BITS > PROD_W) ?
                             (WORD_BITS + 2 * FRAC_BITS) : PROD_W) + 2;

  // Register depths counted from the accepting edge: the norm leaves its last
  // root stage after NORM_LAT registers, a lane's context sits in its fourth
  // register before the delay line starts.
  localparam int NORM_LAT  = 3 + ROOT_W;
  localparam int EARLY_LAT = 4;
  localparam int CTX_DLY   = NORM_LAT - EARLY_LAT;
  localparam int LANE_LAT  = NORM_LAT + 3 + QUO_W;

  localparam int IN_DATA_W  = ((9 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((4 * WORD_BITS + 7) / 8) * 8;

  localparam logic signed [HSUM_W-1:0] RND_HALF = HSUM_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_MUL   = 3'd0,
    ACT_CONJ  = 3'd1,
    ACT_NORM  = 3'd2,
    ACT_INV   = 3'd3,
    ACT_SCALE = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // Operand routing of the Hamilton product: lane i sums x[k]*y[k] over k,
  // subtracting the products whose SUB_MASK bit is set.
  localparam logic [1:0] X_SEL [LANES][LANES] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd3, 2'd1},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam logic [1:0] Y_SEL [LANES][LANES] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd3, 2'd2},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd0, 2'd3, 2'd2, 2'd1}
  };
  localparam logic [LANES-1:0] SUB_MASK [LANES] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

  typedef struct packed {
    logic [ACT_W-1:0]                 action;
    logic                             conj;
    logic [WORD_BITS-1:0]             a;
    logic [LANES-1:0][WORD_BITS-1:0]  x;
    logic [LANES-1:0][WORD_BITS-1:0]  y;
    logic [LANES-1:0]                 sub;
  } lane_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] r;
    logic                 sat;
    logic                 zero;
  } lane_out_t;

  typedef struct packed {
    logic [SQ_SUM_W-1:0] s;
    logic [ROOT_W-1:0]   n;
    logic                zero;
  } norm_t;

endpackage

[rtl/core/quaternion_arithmetic_unit_core.sv]
// Quaternion arithmetic unit: Hamilton product, conjugate, normalize, inverse and scale on
// signed Q16.16 words, one operation per beat. A new beat is taken every cycle while the skid
// register is empty; the depth of the pipeline comes from the
// 33-stage square root of the squared norm followed by the 33-stage divider in each of the
// four component lanes. Bubbles are kept, and a one-beat skid register behind the output
// register lets the pipeline finish its current advance when the sink stalls.
module quaternion_arithmetic_unit_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor from bit 0 up, 32 bits each
  input  logic [qau_pkg::IN_DATA_W-1:0]    in_tdata,
  // action
  input  logic [qau_pkg::ACT_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // r_w, r_x, r_y, r_z from bit 0 up, 32 bits each
  output logic [qau_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status
  output logic [qau_pkg::STAT_W-1:0]       out_tuser
);
  import qau_pkg::*;

  typedef struct packed {
    logic [LANES-1:0][WORD_BITS-1:0] r;
    logic [STAT_W-1:0]               status;
  } res_t;

  logic [LANES-1:0][WORD_BITS-1:0] a_in, b_in;
  logic [WORD_BITS-1:0]            factor_in;
  lane_in_t                        lin  [LANES];
  lane_out_t                       lout [LANES];
  norm_t                           nrm;
  logic                            en;
  logic [LANE_LAT:0]               v_r;
  res_t                            res_r, res_nxt;
  res_t                            out_r, skid_r;
  logic                            out_valid_r, skid_full_r;
  logic                            any_sat, any_zero;
  logic                            deliver;

  assign a_in      = in_tdata[4*WORD_BITS-1:0];
  assign b_in      = in_tdata[8*WORD_BITS-1:4*WORD_BITS];
  assign factor_in = in_tdata[9*WORD_BITS-1:8*WORD_BITS];

  assign en        = ~skid_full_r;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lin[i].action = in_tuser;
      lin[i].conj   = (i != 0);
      lin[i].a      = a_in[i];
      lin[i].sub    = SUB_MASK[i];
      for (int k = 0; k < LANES; k++) begin
        lin[i].x[k] = a_in[X_SEL[i][k]];
        lin[i].y[k] = b_in[Y_SEL[i][k]];
      end
      if (in_tuser == ACT_SCALE) begin
        lin[i].y[0] = factor_in;
      end
    end
  end

  qau_norm u_norm (
    .clk (clk),
    .en  (en),
    .a   (a_in),
    .nrm (nrm)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    qau_lane u_lane (
      .clk      (clk),
      .en       (en),
      .lane_in  (lin[i]),
      .nrm      (nrm),
      .lane_out (lout[i])
    );
  end

  // Merge: a zero norm outranks saturation.
  always_comb begin
    any_sat  = 1'b0;
    any_zero = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      res_nxt.r[i] = lout[i].r;
      any_sat      = any_sat | lout[i].sat;
      any_zero     = any_zero | lout[i].zero;
    end
    priority if (any_zero) begin
      res_nxt.status = ST_ZERO;
    end else if (any_sat) begin
      res_nxt.status = ST_SAT;
    end else begin
      res_nxt.status = ST_OK;
    end
  end

  assign deliver = en & v_r[LANE_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
    if (!out_valid_r || out_tready) begin
      if (skid_full_r) begin
        out_r <= skid_r;
      end else if (deliver) begin
        out_r <= res_r;
      end
    end else if (deliver) begin
      skid_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[LANE_LAT-1:0], in_tvalid};
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= skid_full_r | deliver;
        skid_full_r <= 1'b0;
      end else if (deliver) begin
        skid_full_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_r.r);
  assign out_tuser  = out_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled without an output stall");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |=> $stable(v_r))
    else $error("pipeline advanced while the skid register was full");

endmodule

[rtl/core/qau_norm.sv]
// Squared norm of quaternion A and its integer square root, fully pipelined.
// Depends on qau_pkg; feeds the divisor of every component lane.
module qau_norm (
  input  logic                                            clk,
  input  logic                                            en,
  input  logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0] a,
  output qau_pkg::norm_t                                  nrm
);
  import qau_pkg::*;

  typedef struct packed {
    logic [ROOT_W-1:0]   rt;
    logic [SREM_W-1:0]   rm;
    logic [SQ_SUM_W-1:0] s;
    logic                zero;
  } sq_stage_t;

  // One result bit per stage: shift two radicand bits into the remainder
  // and try to subtract 4*root+1.
  function automatic sq_stage_t sq_step(input sq_stage_t st, input int k);
    sq_stage_t         o;
    logic [RAD_W-1:0]  rad;
    logic [SREM_W+1:0] sh;
    logic [SREM_W+1:0] trial;
    o     = st;
    rad   = RAD_W'(st.s);
    sh    = {st.rm, rad[RAD_W-1-2*k -: 2]};
    trial = (SREM_W+2)'({st.rt, 2'b01});
    if (sh >= trial) begin
      o.rm = SREM_W'(sh - trial);
      o.rt = {st.rt[ROOT_W-2:0], 1'b1};
    end else begin
      o.rm = SREM_W'(sh);
      o.rt = {st.rt[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic signed [PROD_W-1:0] sq_r [LANES];
  logic [PROD_W-1:0]        pr_r [2];
  sq_stage_t                st_r [0:ROOT_W];
  sq_stage_t                st0_nxt;

  always_comb begin
    st0_nxt.rt   = '0;
    st0_nxt.rm   = '0;
    st0_nxt.s    = SQ_SUM_W'(pr_r[0]) + SQ_SUM_W'(pr_r[1]);
    st0_nxt.zero = (pr_r[0] == '0) && (pr_r[1] == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        sq_r[k] <= $signed(a[k]) * $signed(a[k]);
      end
      pr_r[0] <= PROD_W'(sq_r[0]) + PROD_W'(sq_r[1]);
      pr_r[1] <= PROD_W'(sq_r[2]) + PROD_W'(sq_r[3]);
      st_r[0] <= st0_nxt;
      for (int k = 0; k < ROOT_W; k++) begin
        st_r[k+1] <= sq_step(st_r[k], k);
      end
    end
  end

  assign nrm.s    = st_r[ROOT_W].s;
  assign nrm.n    = st_r[ROOT_W].rt;
  assign nrm.zero = st_r[ROOT_W].zero;

endmodule

[rtl/core/qau_lane.sv]
// One result component: product sums, rounding, saturation and a pipelined
// restoring divider for normalize and inverse. Depends on qau_pkg.
module qau_lane (
  input  logic                clk,
  input  logic                en,
  input  qau_pkg::lane_in_t   lane_in,
  input  qau_pkg::norm_t      nrm,
  output qau_pkg::lane_out_t  lane_out
);
  import qau_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic                 conj;
    logic                 neg;
    logic [WORD_BITS-1:0] mag;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] er;
    logic                 esat;
  } ctx_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] q;
    logic [DIV_W-1:0] d2;
    logic             ovf;
    logic             zero;
    ctx_t             ctx;
  } dstage_t;

  // Returns the saturation flag above the clamped word.
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] hi_lim;
    logic signed [RND_W-1:0] lo_lim;
    logic [WORD_BITS:0]      res;
    hi_lim = $signed({{(RND_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
    lo_lim = ~hi_lim;
    if (v > hi_lim) begin
      res = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (v < lo_lim) begin
      res = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, v[WORD_BITS-1:0]};
    end
    return res;
  endfunction

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t        o;
    logic [DIV_W:0] sh;
    o  = s;
    sh = {s.rem, s.low[QUO_W-1]};
    if (sh >= {1'b0, s.d2}) begin
      o.rem = DIV_W'(sh - {1'b0, s.d2});
      o.q   = {s.q[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = sh[DIV_W-1:0];
      o.q   = {s.q[QUO_W-2:0], 1'b0};
    end
    o.low = s.low << 1;
    return o;
  endfunction

  logic signed [PROD_W-1:0] p1_r [LANES];
  logic [LANES-1:0]         sub1_r;
  ctx_t                     ctx1_r, ctx2_r, ctx3_r, ctx4_r;
  ctx_t                     ctx1_nxt, ctx5_nxt;
  logic signed [HSUM_W-1:0] ext [LANES];
  logic signed [HSUM_W-1:0] trm [LANES];
  logic signed [HSUM_W-1:0] s01_r, s23_r, s01_nxt, s23_nxt;
  logic signed [HSUM_W-1:0] t3_r;
  logic signed [HSUM_W-1:0] t3_half;
  logic signed [RND_W-1:0]  rnd4_r;
  logic signed [RND_W-1:0]  a_ext;
  ctx_t                     dly_r [CTX_DLY];

  logic [DIV_W-1:0]         num, den;
  logic [DIV_W-1:0]         n2_r, d2_r, n2_nxt, d2_nxt;
  ctx_t                     ctxp_r;
  logic                     zp_r;
  dstage_t                  ds_r [0:QUO_W];
  dstage_t                  ds0_nxt;

  dstage_t                  fin;
  logic signed [RND_W-1:0]  qs;
  logic [WORD_BITS:0]       dres;
  lane_out_t                lane_out_r, lane_out_nxt;

  // Stage 1: products and operand context.
  always_comb begin
    ctx1_nxt.action = lane_in.action;
    ctx1_nxt.conj   = lane_in.conj;
    ctx1_nxt.neg    = (lane_in.action == ACT_INV && lane_in.conj) ?
                      ~lane_in.a[WORD_BITS-1] : lane_in.a[WORD_BITS-1];
    ctx1_nxt.mag    = lane_in.a[WORD_BITS-1] ? (~lane_in.a + 1'b1) : lane_in.a;
    ctx1_nxt.a      = lane_in.a;
    ctx1_nxt.er     = '0;
    ctx1_nxt.esat   = 1'b0;
  end

  // Stage 2: signed pair sums; a scale passes its single product.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ext[k] = HSUM_W'(p1_r[k]);
      trm[k] = sub1_r[k] ? -ext[k] : ext[k];
    end
    if (ctx1_r.action == ACT_SCALE) begin
      s01_nxt = ext[0];
      s23_nxt = '0;
    end else begin
      s01_nxt = trm[0] + trm[1];
      s23_nxt = trm[2] + trm[3];
    end
  end

  assign t3_half = t3_r + RND_HALF;

  // Stage 5: results that need no division.
  always_comb begin
    ctx5_nxt = ctx4_r;
    a_ext    = RND_W'($signed(ctx4_r.a));
    unique case (ctx4_r.action)
      ACT_MUL, ACT_SCALE: begin
        {ctx5_nxt.esat, ctx5_nxt.er} = sat_word(rnd4_r);
      end
      ACT_CONJ: begin
        if (ctx4_r.conj) begin
          {ctx5_nxt.esat, ctx5_nxt.er} = sat_word(-a_ext);
        end else begin
          {ctx5_nxt.esat, ctx5_nxt.er} = {1'b0, ctx4_r.a};
        end
      end
      default: begin
        {ctx5_nxt.esat, ctx5_nxt.er} = '0;
      end
    endcase
  end

  // Divider setup: round(N/D) is floor((2N + D) / 2D).
  always_comb begin
    if (dly_r[CTX_DLY-1].action == ACT_NORM) begin
      num = DIV_W'(dly_r[CTX_DLY-1].mag) << FRAC_BITS;
      den = DIV_W'(nrm.n);
    end else begin
      num = DIV_W'(dly_r[CTX_DLY-1].mag) << (2 * FRAC_BITS);
      den = DIV_W'(nrm.s);
    end
    n2_nxt = (num << 1) + den;
    d2_nxt = den << 1;
  end

  // Quotient bits above the kept range only show as an overflow.
  always_comb begin
    ds0_nxt.rem  = n2_r >> QUO_W;
    ds0_nxt.low  = n2_r[QUO_W-1:0];
    ds0_nxt.q    = '0;
    ds0_nxt.d2   = d2_r;
    ds0_nxt.ovf  = (n2_r >> QUO_W) >= d2_r;
    ds0_nxt.zero = zp_r;
    ds0_nxt.ctx  = ctxp_r;
  end

  always_comb begin
    fin = ds_r[QUO_W];
    qs  = RND_W'({1'b0, fin.q});
    if (fin.ctx.neg) begin
      qs = -qs;
    end
    dres = sat_word(qs);
    if (fin.ovf) begin
      dres = {1'b1, fin.ctx.neg, {(WORD_BITS-1){~fin.ctx.neg}}};
    end
    lane_out_nxt.zero = 1'b0;
    unique case (fin.ctx.action)
      ACT_NORM: begin
        if (fin.zero) begin
          {lane_out_nxt.sat, lane_out_nxt.r} = {1'b0, fin.ctx.a};
          lane_out_nxt.zero = 1'b1;
        end else begin
          {lane_out_nxt.sat, lane_out_nxt.r} = dres;
        end
      end
      ACT_INV: begin
        if (fin.zero) begin
          {lane_out_nxt.sat, lane_out_nxt.r} = '0;
          lane_out_nxt.zero = 1'b1;
        end else begin
          {lane_out_nxt.sat, lane_out_nxt.r} = dres;
        end
      end
      ACT_MUL, ACT_CONJ, ACT_SCALE: begin
        {lane_out_nxt.sat, lane_out_nxt.r} = {fin.ctx.esat, fin.ctx.er};
      end
      default: begin
        {lane_out_nxt.sat, lane_out_nxt.r} = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        p1_r[k] <= $signed(lane_in.x[k]) * $signed(lane_in.y[k]);
      end
      sub1_r <= lane_in.sub;
      ctx1_r <= ctx1_nxt;
      s01_r  <= s01_nxt;
      s23_r  <= s23_nxt;
      ctx2_r <= ctx1_r;
      t3_r   <= s01_r + s23_r;
      ctx3_r <= ctx2_r;
      rnd4_r <= t3_half[HSUM_W-1:FRAC_BITS];
      ctx4_r <= ctx3_r;
      dly_r[0] <= ctx5_nxt;
      for (int j = 1; j < CTX_DLY; j++) begin
        dly_r[j] <= dly_r[j-1];
      end
      n2_r   <= n2_nxt;
      d2_r   <= d2_nxt;
      ctxp_r <= dly_r[CTX_DLY-1];
      zp_r   <= nrm.zero;
      ds_r[0] <= ds0_nxt;
      for (int k = 0; k < QUO_W; k++) begin
        ds_r[k+1] <= div_step(ds_r[k]);
      end
      lane_out_r <= lane_out_nxt;
    end
  end

  assign lane_out = lane_out_r;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench of quaternion_arithmetic_unit_core: stream beats in, compare results.
// Depends on qau_pkg for the action and status codes and the stream widths.
`timescale 1ns / 1ps

module tb;
  import qau_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [31:0] r [4];
    status_t            st;
  } quat_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  quat_result_t pending_results [$];
  int  errors = 0;
  int  beats_sent = 0;
  int  beats_checked = 0;
  int  cycles = 0;
  bit  src_bursty = 1'b1;
  bit  sink_bursty = 1'b1;
  bit  hold_req = 1'b0;
  int  op_seen [8];

  quaternion_arithmetic_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Clamp a wide value to the word range, raising the flag when it did not fit.
  function automatic logic signed [31:0] clamp_word(logic signed [127:0] v, ref bit ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] round_q(logic signed [127:0] v);
    return (v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // Rounded division, half away from zero, with the sign given separately.
  function automatic logic signed [127:0] div_near(bit neg, logic [127:0] num, logic [127:0] d);
    logic [127:0] q;
    q = ((num << 1) + d) / (d << 1);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [127:0] floor_sqrt(logic [127:0] s);
    logic [127:0] root, t;
    root = '0;
    for (int b = 50; b >= 0; b--) begin
      t = root | (128'd1 << b);
      if (s >= t * t) root = t;
    end
    return root;
  endfunction

  function automatic quat_result_t predict_quat(logic [2:0] act, logic signed [31:0] a [4],
                                                logic signed [31:0] b [4],
                                                logic signed [31:0] f);
    quat_result_t res;
    logic signed [127:0] wa [4], wb [4], wf, t [4], c;
    logic [127:0] s, n;
    bit ovf;
    ovf = 1'b0;
    res.st = ST_OK;
    for (int i = 0; i < 4; i++) begin
      wa[i] = a[i];
      wb[i] = b[i];
      res.r[i] = '0;
    end
    wf = f;
    s = wa[0]*wa[0] + wa[1]*wa[1] + wa[2]*wa[2] + wa[3]*wa[3];
    case (act)
      ACT_MUL: begin
        t[0] = wa[0]*wb[0] - wa[1]*wb[1] - wa[2]*wb[2] - wa[3]*wb[3];
        t[1] = wa[1]*wb[0] + wa[0]*wb[1] + wa[2]*wb[3] - wa[3]*wb[2];
        t[2] = wa[2]*wb[0] + wa[0]*wb[2] + wa[3]*wb[1] - wa[1]*wb[3];
        t[3] = wa[3]*wb[0] + wa[0]*wb[3] + wa[1]*wb[2] - wa[2]*wb[1];
        for (int i = 0; i < 4; i++) res.r[i] = clamp_word(round_q(t[i]), ovf);
      end
      ACT_CONJ: begin
        res.r[0] = a[0];
        for (int i = 1; i < 4; i++) res.r[i] = clamp_word(-wa[i], ovf);
      end
      ACT_NORM: begin
        if (s == 0) begin
          for (int i = 0; i < 4; i++) res.r[i] = a[i];
          res.st = ST_ZERO;
        end else begin
          n = floor_sqrt(s);
          for (int i = 0; i < 4; i++) begin
            c = wa[i];
            res.r[i] = clamp_word(div_near(c < 0, (c < 0 ? -c : c) << FRAC_BITS, n), ovf);
          end
        end
      end
      ACT_INV: begin
        if (s == 0) res.st = ST_ZERO;
        else begin
          for (int i = 0; i < 4; i++) begin
            c = (i == 0) ? wa[0] : -wa[i];
            res.r[i] = clamp_word(div_near(c < 0, (c < 0 ? -c : c) << (2 * FRAC_BITS), s),
                                  ovf);
          end
        end
      end
      ACT_SCALE: begin
        for (int i = 0; i < 4; i++) res.r[i] = clamp_word(round_q(wa[i] * wf), ovf);
      end
      default: ;
    endcase
    if (res.st == ST_OK && ovf) res.st = ST_SAT;
    return res;
  endfunction

  // Offers one beat, waits for acceptance, records the prediction, then maybe idles.
  task automatic send_op(logic [2:0] act, logic signed [31:0] a [4], logic signed [31:0] b [4],
                         logic signed [31:0] f);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {f, b[3], b[2], b[1], b[0], a[3], a[2], a[1], a[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_quat(act, a, b, f));
    beats_sent++;
    op_seen[act]++;
    if (src_bursty && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 32'sh7fffffff - $urandom_range(0, 3);
      2:       return 32'sh80000000 + $urandom_range(0, 3);
      3:       return 32'sd0;
      4, 5:    return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
    endcase
  endfunction

  task automatic send_random(logic [2:0] act);
    logic signed [31:0] a [4], b [4];
    for (int i = 0; i < 4; i++) begin
      a[i] = rand_word();
      b[i] = rand_word();
    end
    send_op(act, a, b, rand_word());
  endtask

  function automatic logic [2:0] pick_op();
    return ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
  endfunction

  always @(posedge clk) begin
    quat_result_t want;
    logic signed [31:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting: tdata=%h tuser=%0d",
               out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        for (int i = 0; i < 4; i++) begin
          got = out_tdata[32*i +: 32];
          if (got !== want.r[i]) begin
            $error("field %s: expected %0d actual %0d",
                   i == 0 ? "r_w" : i == 1 ? "r_x" : i == 2 ? "r_y" : "r_z", want.r[i], got);
            errors++;
          end
        end
        if (out_tuser !== want.st) begin
          $error("field status: expected %0d actual %0d", want.st, out_tuser);
          errors++;
        end
      end
    end
  end

  // Sink side: random stall bursts, or one long hold-off when asked.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_bursty && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_directed();
    logic signed [31:0] a [4], b [4], z [4], one [4];
    z = '{0, 0, 0, 0};
    one = '{32'sh10000, 0, 0, 0};
    a = '{32'sh10000, 32'sh20000, -32'sh8000, 32'sh1};
    b = '{-32'sh18000, 32'sh4000, 32'sh10000, -32'sh30000};
    for (int op = 0; op < 8; op++) send_op(3'(op), a, b, -32'sh28000);
    // Zero norm for normalize and inverse, the zero quaternion in a product, and the inverse of one.
    send_op(ACT_NORM, z, b, 0);
    send_op(ACT_INV, z, b, 0);
    send_op(ACT_MUL, z, z, 0);
    send_op(ACT_INV, one, b, 0);
    // Conjugating the most negative word saturates.
    a = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    send_op(ACT_CONJ, a, a, 0);
    send_op(ACT_MUL, a, a, 0);
    send_op(ACT_NORM, a, a, 0);
    send_op(ACT_INV, a, a, 0);
    send_op(ACT_SCALE, a, a, 32'sh80000000);
    a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    b = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    send_op(ACT_MUL, a, b, 0);
    send_op(ACT_SCALE, a, b, 32'sh7fffffff);
    send_op(ACT_INV, a, b, 0);
    // Tiny norm makes the inverse overflow.
    a = '{32'sd1, 0, 0, 0};
    send_op(ACT_INV, a, b, 0);
    a = '{0, 0, 0, -32'sd1};
    send_op(ACT_NORM, a, b, 0);
    send_op(ACT_INV, a, b, 0);
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random(pick_op());
  endtask

  task automatic test_backpressure();
    wait (out_tready);
    hold_req = 1'b1;
    repeat (150) send_random(pick_op());
  endtask

  task automatic test_full_rate(int count);
    src_bursty = 1'b0;
    sink_bursty = 1'b0;
    repeat (count) send_random(pick_op());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(200);
    test_backpressure();
    test_full_rate(60);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats, checked %0d results; mul %0d conj %0d norm %0d inv %0d scale %0d",
             beats_sent, beats_checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
             op_seen[4]);
    $display("Undefined actions %0d, with stall bursts, a long sink hold-off and full rate.",
             op_seen[5] + op_seen[6] + op_seen[7]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
